FILE: rtl/piecewise_linear_evaluator_defines.svh
// Assertion macros shared by the evaluator RTL.
`ifndef PIECEWISE_LINEAR_EVALUATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_EVALUATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication outside reset.
`define PLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/ple_pkg.sv
// Package: constants, payload types and queue entry for the evaluator.
package ple_pkg;
    localparam int MAX_KNOTS_DEF  = 16;
    localparam int VALUE_BITS_DEF = 16;
    localparam int IDX_BITS       = 4;
    localparam int CNT_BITS       = 5;
    localparam int VAL_BITS       = 16;

    localparam logic MODE_EVAL  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [1:0] ST_INTERP   = 2'd0;
    localparam logic [1:0] ST_CLAMP_LO = 2'd1;
    localparam logic [1:0] ST_CLAMP_HI = 2'd2;
    localparam logic [1:0] ST_NO_SEG   = 2'd3;

    typedef struct packed {
        logic                       mode;
        logic [IDX_BITS-1:0]        knot_index;
        logic signed [VAL_BITS-1:0] knot_x_value;
        logic signed [VAL_BITS-1:0] knot_y_value;
        logic signed [VAL_BITS-1:0] query_x;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_BITS-1:0] result_y;
        logic [IDX_BITS-1:0]        segment_used;
        logic [1:0]                 status;
    } out_item_t;
endpackage

FILE: rtl/ple_front.sv
// Front end: accepts transactions into a two-entry queue.
module ple_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ple_pkg::in_item_t   item,
    output logic                q_valid,
    output ple_pkg::in_item_t   q_item,
    input  logic                q_pop,
    output logic                q_empty
);
    ple_pkg::in_item_t ent_reg [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg;
    logic              push;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_empty = (cnt_reg == 2'd0);
    assign q_item  = ent_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

FILE: rtl/ple_back.sv
// Back end: knot tables, segment search and serial division.
`include "piecewise_linear_evaluator_defines.svh"
module ple_back
#(
    parameter int MAX_KNOTS = ple_pkg::MAX_KNOTS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [ple_pkg::CNT_BITS-1:0] knot_count,
    input  logic                      q_valid,
    input  ple_pkg::in_item_t         q_item,
    output logic                      q_pop,
    output logic                      result_valid,
    output ple_pkg::out_item_t        result
);
    localparam int VB = ple_pkg::VAL_BITS;
    localparam int IB = ple_pkg::IDX_BITS;
    localparam int WB = VB + 1;
    localparam int DB = 2 * WB;

    typedef enum logic [2:0] {S_IDLE, S_CLAMP, S_CACHE, S_SCAN, S_LOAD, S_DIV, S_DONE} state_t;

    logic signed [VB-1:0] xt_reg [MAX_KNOTS];
    logic signed [VB-1:0] yt_reg [MAX_KNOTS];

    state_t               state_reg;
    logic [IB-1:0]        cache_reg, seg_reg, last_reg;
    logic signed [VB-1:0] qx_reg;
    logic signed [VB-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [WB-1:0]        w_reg, b_reg, a_reg;
    logic [DB-1:0]        r_reg;
    logic [WB-1:0]        q_reg;
    logic [5:0]           it_reg;
    logic                 neg_reg;
    logic                 rv_reg;
    ple_pkg::out_item_t   res_reg;

    logic [ple_pkg::CNT_BITS-1:0] n_eff;
    logic [IB-1:0]        nseg_m1;
    logic signed [VB:0]   dy;
    logic [DB-1:0]        r_sh, r_try;
    logic                 fit;
    logic signed [VB+1:0] res_full;
    logic signed [VB-1:0] res_sat;
    logic signed [VB-1:0] xa, xb;
    logic                 inseg;
    logic [WB-1:0]        q_next;

    always_comb
    begin
        n_eff = knot_count;
        if (knot_count < ple_pkg::CNT_BITS'(2))
        begin
            n_eff = ple_pkg::CNT_BITS'(2);
        end
        if (knot_count > ple_pkg::CNT_BITS'(MAX_KNOTS))
        begin
            n_eff = ple_pkg::CNT_BITS'(MAX_KNOTS);
        end
        nseg_m1 = IB'(n_eff - ple_pkg::CNT_BITS'(2));
        xa      = xt_reg[seg_reg];
        xb      = xt_reg[IB'(seg_reg + IB'(1))];
        inseg   = (xa <= qx_reg) && (qx_reg <= xb);
        dy      = {y1_reg[VB-1], y1_reg} - {y0_reg[VB-1], y0_reg};
        // restoring division: (a*b) in r, divided by w
        r_sh    = {r_reg[DB-2:0], 1'b0};
        r_try   = r_sh - {w_reg, {WB{1'b0}}};
        fit     = (r_sh >= {w_reg, {WB{1'b0}}});
        q_next  = {q_reg[WB-2:0], fit};
        res_full = neg_reg ? ((VB+2)'(y0_reg) - (VB+2)'($signed({1'b0, q_reg})))
                           : ((VB+2)'(y0_reg) + (VB+2)'($signed({1'b0, q_reg})));
        if (res_full > (VB+2)'(32767))
        begin
            res_sat = 16'sh7fff;
        end
        else if (res_full < -(VB+2)'(32768))
        begin
            res_sat = 16'sh8000;
        end
        else
        begin
            res_sat = VB'(res_full);
        end
    end

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign result_valid = rv_reg;
    assign result       = res_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.mode == ple_pkg::MODE_WRITE)
        begin
            xt_reg[q_item.knot_index] <= q_item.knot_x_value;
            yt_reg[q_item.knot_index] <= q_item.knot_y_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cache_reg <= '0;
            rv_reg    <= 1'b0;
            seg_reg   <= '0;
            last_reg  <= '0;
            qx_reg    <= '0;
            x0_reg    <= '0;
            x1_reg    <= '0;
            y0_reg    <= '0;
            y1_reg    <= '0;
            w_reg     <= '0;
            b_reg     <= '0;
            a_reg     <= '0;
            r_reg     <= '0;
            q_reg     <= '0;
            it_reg    <= '0;
            neg_reg   <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            rv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && q_item.mode == ple_pkg::MODE_EVAL)
                    begin
                        qx_reg    <= q_item.query_x;
                        last_reg  <= IB'(n_eff - ple_pkg::CNT_BITS'(1));
                        state_reg <= S_CLAMP;
                    end
                end
                S_CLAMP:
                begin
                    if (qx_reg <= xt_reg[0])
                    begin
                        res_reg   <= '{yt_reg[0], '0, ple_pkg::ST_CLAMP_LO};
                        state_reg <= S_DONE;
                    end
                    else if (qx_reg >= xt_reg[last_reg])
                    begin
                        res_reg   <= '{yt_reg[last_reg], nseg_m1, ple_pkg::ST_CLAMP_HI};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        seg_reg   <= cache_reg;
                        state_reg <= (cache_reg <= nseg_m1) ? S_CACHE : S_SCAN;
                        if (cache_reg > nseg_m1)
                        begin
                            seg_reg <= '0;
                        end
                    end
                end
                S_CACHE:
                begin
                    if (inseg)
                    begin
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        seg_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (inseg)
                    begin
                        cache_reg <= seg_reg;
                        state_reg <= S_LOAD;
                    end
                    else if (seg_reg == nseg_m1)
                    begin
                        res_reg   <= '{'0, '0, ple_pkg::ST_NO_SEG};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        seg_reg <= seg_reg + IB'(1);
                    end
                end
                S_LOAD:
                begin
                    x0_reg    <= xa;
                    x1_reg    <= xb;
                    y0_reg    <= yt_reg[seg_reg];
                    y1_reg    <= yt_reg[IB'(seg_reg + IB'(1))];
                    w_reg     <= WB'($signed(xb) - $signed(xa));
                    b_reg     <= WB'($signed(qx_reg) - $signed(xa));
                    it_reg    <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // first step: latch |dy| and its sign; forming |dy| * b bit by bit is costly, so multiply once
                    if (it_reg == 6'd0)
                    begin
                        neg_reg <= dy[VB];
                        a_reg   <= dy[VB] ? WB'(-dy) : WB'(dy);
                        it_reg  <= 6'd1;
                        if (x1_reg <= x0_reg)
                        begin
                            res_reg   <= '{y0_reg, seg_reg, ple_pkg::ST_INTERP};
                            state_reg <= S_DONE;
                        end
                    end
                    else if (it_reg == 6'd1)
                    begin
                        r_reg  <= DB'(a_reg * b_reg);
                        q_reg  <= '0;
                        it_reg <= 6'd2;
                    end
                    else if (it_reg == 6'd2)
                    begin
                        // quotient fits WB bits since b <= w
                        r_reg  <= r_reg;
                        it_reg <= 6'd3;
                    end
                    else if (it_reg < 6'(3 + WB))
                    begin
                        r_reg  <= fit ? r_try : r_sh;
                        q_reg  <= q_next;
                        it_reg <= it_reg + 6'd1;
                    end
                    else
                    begin
                        res_reg   <= '{res_sat, seg_reg, ple_pkg::ST_INTERP};
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    rv_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PLE_ASSERT_NXT(a_done_strobe, clk, rst_n, state_reg == S_DONE, rv_reg)
    `PLE_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, state_reg == S_IDLE)
    `PLE_ASSERT_IMP(a_clamp_lo_seg, clk, rst_n,
        rv_reg && res_reg.status == ple_pkg::ST_CLAMP_LO, res_reg.segment_used == '0)
endmodule

FILE: rtl/piecewise_linear_evaluator.sv
// Top level of the piecewise-linear evaluator.
// channel | signals                         | handshake
// input   | start, busy, in_item             | start && !busy
// result  | result_valid, result_item        | one-cycle strobe
// config  | knot_count_we, knot_count_wdata  | we high
// Knot write: stored as the back end pops it from the queue. Clamped query: no
// segment search. Interpolation: a probe of the cached segment, a scan of the
// segments in use on a miss, a multiply and a 17-step division.
// The back end handles one transaction at a time and pops the next only when idle.
// Reset: knot_count 2, cache 0, queue empty; knot tables undefined until written.
// busy rises when the two-entry queue is full; results cannot be stalled.
`include "piecewise_linear_evaluator_defines.svh"
module piecewise_linear_evaluator
#(
    parameter int MAX_KNOTS = ple_pkg::MAX_KNOTS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  ple_pkg::in_item_t            in_item,
    output logic                         result_valid,
    output ple_pkg::out_item_t           result_item,
    input  logic                         knot_count_we,
    input  logic [ple_pkg::CNT_BITS-1:0] knot_count_wdata
);
    logic [ple_pkg::CNT_BITS-1:0] knot_count_reg;
    logic              q_valid, q_pop, q_empty;
    ple_pkg::in_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knot_count_reg <= ple_pkg::CNT_BITS'(2);
        end
        else if (knot_count_we)
        begin
            knot_count_reg <= knot_count_wdata;
        end
    end

    ple_front u_front
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(in_item),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .q_empty(q_empty)
    );

    ple_back #(.MAX_KNOTS(MAX_KNOTS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .knot_count(knot_count_reg),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .result_valid(result_valid), .result(result_item)
    );

    `PLE_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, !q_empty)
    `PLE_ASSERT_NXT(a_full_busy, clk, rst_n, start && !busy && q_valid && !q_pop, busy)
    `PLE_ASSERT_IMP(a_valid_ne, clk, rst_n, q_valid, !q_empty)
endmodule

FILE: sim/tb_top.sv
// Testbench for the piecewise-linear evaluator: queued driver, result monitor, predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEP_LATENCY = 120;
    localparam int STALL_LIMIT  = 3000;
    localparam int PRINT_CAP    = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    ple_pkg::in_item_t  in_item = '0;
    logic               result_valid;
    ple_pkg::out_item_t result_item;
    logic               knot_count_we = 1'b0;
    logic [4:0]         knot_count_wdata = 5'd2;

    piecewise_linear_evaluator uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .in_item          (in_item),
        .result_valid     (result_valid),
        .result_item      (result_item),
        .knot_count_we    (knot_count_we),
        .knot_count_wdata (knot_count_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic signed [15:0] knot_x [16];
    logic signed [15:0] knot_y [16];
    logic [3:0]         seg_cache = '0;
    logic [4:0]         knots_in_use = 5'd2;

    ple_pkg::in_item_t  pending_items [$];
    ple_pkg::out_item_t expected_results [$];
    int                 mismatches = 0;
    int                 idle_cycles = 0;
    int                 gap_left = 0;
    bit                 no_idle = 1'b0;
    ple_pkg::out_item_t head;

    // stimulus-side view of the table
    int plan_x [16];
    int plan_n = 2;

    function automatic bit covers(input int s, input longint x);
        return knot_x[s] <= x && x <= knot_x[s + 1];
    endfunction

    function automatic logic signed [15:0] lerp(input int s, input longint x);
        longint x0, x1, y0, y1, dy, mag, q, res;
        x0 = knot_x[s];
        x1 = knot_x[s + 1];
        y0 = knot_y[s];
        y1 = knot_y[s + 1];
        if (x1 <= x0)
            return y0[15:0];
        dy  = y1 - y0;
        mag = dy < 0 ? -dy : dy;
        q   = (mag * (x - x0)) / (x1 - x0);
        res = dy < 0 ? y0 - q : y0 + q;
        if (res > 32767)
            res = 32767;
        if (res < -32768)
            res = -32768;
        return res[15:0];
    endfunction

    function automatic void predict(input ple_pkg::in_item_t it);
        int                 n, nseg, s, i;
        longint             x;
        ple_pkg::out_item_t r;
        if (it.mode == ple_pkg::MODE_WRITE)
        begin
            knot_x[it.knot_index] = it.knot_x_value;
            knot_y[it.knot_index] = it.knot_y_value;
            return;
        end
        n = knots_in_use < 2 ? 2 : (knots_in_use > 16 ? 16 : int'(knots_in_use));
        nseg = n - 1;
        x = it.query_x;
        r = '0;
        if (x <= knot_x[0])
        begin
            r.result_y = knot_y[0];
            r.status   = ple_pkg::ST_CLAMP_LO;
        end
        else if (x >= knot_x[n - 1])
        begin
            r.result_y     = knot_y[n - 1];
            r.segment_used = 4'(nseg - 1);
            r.status       = ple_pkg::ST_CLAMP_HI;
        end
        else
        begin
            s = -1;
            if (seg_cache < nseg && covers(seg_cache, x))
                s = seg_cache;
            else
            begin
                for (i = 0; i < nseg && s < 0; i++)
                    if (covers(i, x))
                        s = i;
                if (s >= 0)
                    seg_cache = 4'(s);
            end
            if (s < 0)
                r.status = ple_pkg::ST_NO_SEG;
            else
            begin
                r.result_y     = lerp(s, x);
                r.segment_used = 4'(s);
                r.status       = ple_pkg::ST_INTERP;
            end
        end
        expected_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predict(in_item);
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                in_item  <= pending_items.pop_front();
                start    <= 1'b1;
                gap_left <= no_idle ? 0 : $urandom_range(0, 17);
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected transaction", -1, int'(result_item.status));
            else
            begin
                head = expected_results.pop_front();
                if (result_item.result_y !== head.result_y)
                    report_mismatch("result_y", head.result_y, result_item.result_y);
                if (result_item.segment_used !== head.segment_used)
                    report_mismatch("segment_used", head.segment_used, result_item.segment_used);
                if (result_item.status !== head.status)
                    report_mismatch("status", head.status, result_item.status);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic ple_pkg::in_item_t knot_write(input int idx, input int x, input int y);
        ple_pkg::in_item_t it;
        it = '0;
        it.mode         = ple_pkg::MODE_WRITE;
        it.knot_index   = 4'(idx);
        it.knot_x_value = 16'(x);
        it.knot_y_value = 16'(y);
        it.query_x      = 16'($urandom);
        return it;
    endfunction

    function automatic ple_pkg::in_item_t query(input int x);
        ple_pkg::in_item_t it;
        it = '0;
        it.mode         = ple_pkg::MODE_EVAL;
        it.knot_index   = 4'($urandom);
        it.knot_x_value = 16'($urandom);
        it.knot_y_value = 16'($urandom);
        it.query_x      = 16'(x);
        return it;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || start || gap_left > 0)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (STEP_LATENCY) @(posedge clk);
    endtask

    task automatic set_count(input int v);
        drain();
        knot_count_we    <= 1'b1;
        knot_count_wdata <= 5'(v);
        @(posedge clk);
        knot_count_we <= 1'b0;
        knots_in_use = 5'(v);
        plan_n = v < 2 ? 2 : (v > 16 ? 16 : v);
    endtask

    task automatic build_table(input bit dense);
        int v [16];
        int i, base;
        base = $urandom_range(0, 60000) - 32768;
        for (i = 0; i < 16; i++)
        begin
            if (dense)
            begin
                v[i] = base;
                base = base + $urandom_range(0, 40);
                if (base > 32767)
                    base = 32767;
            end
            else
                v[i] = int'($urandom_range(0, 65535)) - 32768;
        end
        v.sort();
        if ($urandom_range(0, 3) == 0)
        begin
            v[0]  = -32768;
            v[15] = 32767;
        end
        for (i = 0; i < 16; i++)
        begin
            plan_x[i] = v[i];
            pending_items.push_back(knot_write(i, v[i], int'($urandom_range(0, 65535)) - 32768));
        end
    endtask

    task automatic random_items(input int count);
        int i, r, lo, hi;
        for (i = 0; i < count; i++)
        begin
            r  = $urandom_range(0, 99);
            lo = plan_x[0];
            hi = plan_x[plan_n - 1];
            if (r < 8)
                pending_items.push_back(knot_write($urandom_range(0, 15),
                    int'($urandom_range(0, 65535)) - 32768,
                    int'($urandom_range(0, 65535)) - 32768));
            else if (r < 30)
                pending_items.push_back(query(int'($urandom_range(0, 65535)) - 32768));
            else if (r < 40)
                pending_items.push_back(query(plan_x[$urandom_range(0, plan_n - 1)]));
            else
                pending_items.push_back(query(lo + int'($urandom_range(0, hi - lo))));
        end
    endtask

    initial
    begin
        int counts [10] = '{16, 0, 31, 7, 17, 1, 12, 3, 16, 2};
        int p;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // two knots at reset count: full-scale slope, clamps at both extremes
        plan_x[0] = -32768;
        plan_x[1] = 32767;
        no_idle = 1'b1;
        pending_items.push_back(knot_write(0, -32768, 32767));
        pending_items.push_back(knot_write(1, 32767, -32768));
        pending_items.push_back(query(-32768));
        pending_items.push_back(query(32767));
        pending_items.push_back(query(0));
        pending_items.push_back(query(1));
        pending_items.push_back(query(-1));
        pending_items.push_back(query(32766));
        // unsorted pair: every query clamps low, none reaches the segment search
        pending_items.push_back(knot_write(0, 100, 5));
        pending_items.push_back(knot_write(1, -100, 7));
        pending_items.push_back(query(100));
        pending_items.push_back(query(-100));
        pending_items.push_back(query(0));
        // four knots with a zero-width last segment; a query at its x clamps high
        set_count(4);
        pending_items.push_back(knot_write(0, -10, -32768));
        pending_items.push_back(knot_write(1, 0, 32767));
        pending_items.push_back(knot_write(2, 10, 1000));
        pending_items.push_back(knot_write(3, 10, -1000));
        pending_items.push_back(query(5));
        pending_items.push_back(query(-5));
        pending_items.push_back(query(10));
        pending_items.push_back(query(9));
        pending_items.push_back(query(0));

        for (p = 0; p < 10; p++)
        begin
            set_count(counts[p]);
            no_idle = (p % 3 == 1);
            build_table(p[0]);
            random_items(90);
            if (p == 4)
                drain();
            random_items(70);
        end

        drain();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_front.sv
rtl/ple_back.sv
rtl/piecewise_linear_evaluator.sv
sim/tb_top.sv
